// ----- hw/rtl/bfd_pkg.sv -----
// ----------------------------------------------------------------------------
// Byte frame deframer package
// Shared types and constants for the frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfd_pkg;

    // Field widths fixed by the frame format
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 5;
    localparam int IDX_W  = 4;
    localparam int CFG_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_W-1:0] REG_HEAD_BYTE  = 2'd0;
    localparam logic [CFG_W-1:0] REG_TAIL_BYTE  = 2'd1;
    localparam logic [CFG_W-1:0] REG_MAX_LENGTH = 2'd2;

    // Register reset values
    localparam logic [BYTE_W-1:0] HEAD_BYTE_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] TAIL_BYTE_RST  = 8'h55;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 5'd16;

    // Parser and drain phases
    typedef enum logic [2:0] {
        PH_HEAD,
        PH_LEN,
        PH_DATA,
        PH_SUM,
        PH_TAIL,
        PH_READ,
        PH_LOAD
    } t_phase;

endpackage

`default_nettype wire

// ----- hw/rtl/bfd_in_if.sv -----
// ----------------------------------------------------------------------------
// Deframer input channel
// Valid/ready channel carrying one received byte per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bfd_in_if;
    logic                        valid;
    logic                        ready;
    logic [bfd_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bfd_out_if.sv -----
// ----------------------------------------------------------------------------
// Deframer output channel
// Valid/ready channel carrying one payload result per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bfd_out_if;
    logic                        valid;
    logic                        ready;
    logic [bfd_pkg::BYTE_W-1:0]  payload_byte;
    logic [bfd_pkg::IDX_W-1:0]   byte_index;
    logic [bfd_pkg::LEN_W-1:0]   frame_length;
    logic                        has_payload;
    logic                        last;

    modport source (output valid, output payload_byte, output byte_index,
                    output frame_length, output has_payload, output last,
                    input ready);
    modport sink   (input valid, input payload_byte, input byte_index,
                    input frame_length, input has_payload, input last,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bfd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Deframer configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bfd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bfd_pkg::CFG_W-1:0]   index;
    logic [bfd_pkg::BYTE_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/byte_frame_deframer_core.sv -----
// ----------------------------------------------------------------------------
// Byte frame deframer core
// Parses head, length, payload, XOR checksum, tail frames from a byte stream
// and drains the payload of each good frame as a run of results.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one received byte per transfer. Accepted while the parser runs;
//            a frame's payload goes to the payload RAM as it arrives.
//   o_out  : one result per payload byte of a completed frame, or a single
//            result with has_payload low for an empty frame. Output register
//            decouples the sides; the next byte may be taken while the last
//            result still waits.
//   i_cfg  : register writes (0 head_byte, 1 tail_byte, 2 max_length),
//            always ready; write only while idle. Other indexes are ignored.
// Drain: on a good tail the input stalls while the payload RAM is read back,
//   one result at a time: RAM read step, then output load step (an empty
//   frame goes straight to the load step).
// Reset: synchronous, active low; parser returns to head-wait, registers to
//   0xAA / 0x55 / 16. The payload RAM is not cleared; it is only read where
//   written in the same frame.
// Stall: a stalled receiver holds the drain in its load step; no result lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module byte_frame_deframer_core #(
    parameter int PAYLOAD_DEPTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bfd_in_if.sink      i_in,
    bfd_out_if.source   o_out,
    bfd_cfg_if.sink     i_cfg
);

    localparam int BW = bfd_pkg::BYTE_W;
    localparam int LW = bfd_pkg::LEN_W;
    localparam int IW = bfd_pkg::IDX_W;
    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam logic [BW-1:0] DEPTH_B = BW'(PAYLOAD_DEPTH);

    // Configuration registers
    logic [BW-1:0] r_head_byte;
    logic [BW-1:0] r_tail_byte;
    logic [LW-1:0] r_max_length;

    // Parser state
    bfd_pkg::t_phase r_phase, n_phase;
    logic [LW-1:0]   r_len, n_len;
    logic [LW-1:0]   r_fill, n_fill;
    logic [BW-1:0]   r_xor, n_xor;
    logic [LW-1:0]   r_k, n_k;

    // Output register
    logic            r_out_valid, n_out_valid;
    logic [BW-1:0]   r_out_pay, n_out_pay;
    logic [IW-1:0]   r_out_idx, n_out_idx;
    logic [LW-1:0]   r_out_len, n_out_len;
    logic            r_out_has, n_out_has;
    logic            r_out_last, n_out_last;

    // Payload RAM
    logic [BW-1:0]   r_mem [PAYLOAD_DEPTH];
    logic [BW-1:0]   r_rd_data;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [AW-1:0]   mem_ra;

    logic            in_xfer;
    logic            out_free;
    logic [BW-1:0]   b;
    logic [LW-1:0]   limit;
    logic            parsing;

    assign b        = i_in.data_byte;
    assign parsing  = !(r_phase inside {bfd_pkg::PH_READ, bfd_pkg::PH_LOAD});
    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign limit    = ({3'b000, r_max_length} > DEPTH_B) ? LW'(DEPTH_B) : r_max_length;
    assign mem_wa   = AW'(r_fill);
    assign mem_ra   = AW'(r_k);

    assign i_in.ready  = parsing;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid        = r_out_valid;
    assign o_out.payload_byte = r_out_pay;
    assign o_out.byte_index   = r_out_idx;
    assign o_out.frame_length = r_out_len;
    assign o_out.has_payload  = r_out_has;
    assign o_out.last         = r_out_last;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_byte  <= bfd_pkg::HEAD_BYTE_RST;
            r_tail_byte  <= bfd_pkg::TAIL_BYTE_RST;
            r_max_length <= bfd_pkg::MAX_LENGTH_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bfd_pkg::REG_HEAD_BYTE:  r_head_byte  <= i_cfg.data;
                bfd_pkg::REG_TAIL_BYTE:  r_tail_byte  <= i_cfg.data;
                bfd_pkg::REG_MAX_LENGTH: r_max_length <= i_cfg.data[LW-1:0];
                default: ;
            endcase
        end
    end

    // Next state, RAM write and output load
    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_fill      = r_fill;
        n_xor       = r_xor;
        n_k         = r_k;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_pay   = r_out_pay;
        n_out_idx   = r_out_idx;
        n_out_len   = r_out_len;
        n_out_has   = r_out_has;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;

        case (r_phase)
            bfd_pkg::PH_READ: begin
                // RAM read at r_k in flight
                n_phase = bfd_pkg::PH_LOAD;
            end
            bfd_pkg::PH_LOAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_len   = r_len;
                    if (r_len == '0) begin
                        n_out_pay  = '0;
                        n_out_idx  = '0;
                        n_out_has  = 1'b0;
                        n_out_last = 1'b1;
                        n_phase    = bfd_pkg::PH_HEAD;
                    end else begin
                        n_out_pay  = r_rd_data;
                        n_out_idx  = r_k[IW-1:0];
                        n_out_has  = 1'b1;
                        n_out_last = (r_k + 1'b1 == r_len);
                        n_k        = r_k + 1'b1;
                        n_phase    = (r_k + 1'b1 == r_len) ? bfd_pkg::PH_HEAD
                                                           : bfd_pkg::PH_READ;
                    end
                end
            end
            default: begin
                if (in_xfer) begin
                    // recovery unless a phase below says otherwise
                    case (r_phase)
                        bfd_pkg::PH_HEAD: begin
                            if (b == r_head_byte) begin
                                n_phase = bfd_pkg::PH_LEN;
                            end
                        end
                        bfd_pkg::PH_LEN: begin
                            if (b > {3'b000, limit}) begin
                                n_len   = '0;
                                n_fill  = '0;
                                n_xor   = '0;
                                n_phase = (b == r_head_byte) ? bfd_pkg::PH_LEN
                                                             : bfd_pkg::PH_HEAD;
                            end else begin
                                n_len   = b[LW-1:0];
                                n_fill  = '0;
                                n_xor   = b;
                                n_phase = (b == '0) ? bfd_pkg::PH_SUM : bfd_pkg::PH_DATA;
                            end
                        end
                        bfd_pkg::PH_DATA: begin
                            mem_we = 1'b1;
                            n_xor  = r_xor ^ b;
                            n_fill = r_fill + 1'b1;
                            if (r_fill + 1'b1 >= r_len) begin
                                n_phase = bfd_pkg::PH_SUM;
                            end
                        end
                        bfd_pkg::PH_SUM: begin
                            if (b == r_xor) begin
                                n_phase = bfd_pkg::PH_TAIL;
                            end else begin
                                n_len   = '0;
                                n_fill  = '0;
                                n_xor   = '0;
                                n_phase = (b == r_head_byte) ? bfd_pkg::PH_LEN
                                                             : bfd_pkg::PH_HEAD;
                            end
                        end
                        bfd_pkg::PH_TAIL: begin
                            if (b == r_tail_byte) begin
                                n_k     = '0;
                                n_phase = (r_len == '0) ? bfd_pkg::PH_LOAD
                                                        : bfd_pkg::PH_READ;
                            end else begin
                                n_len   = '0;
                                n_fill  = '0;
                                n_xor   = '0;
                                n_phase = (b == r_head_byte) ? bfd_pkg::PH_LEN
                                                             : bfd_pkg::PH_HEAD;
                            end
                        end
                        default: begin
                            n_len   = '0;
                            n_fill  = '0;
                            n_xor   = '0;
                            n_phase = (b == r_head_byte) ? bfd_pkg::PH_LEN
                                                         : bfd_pkg::PH_HEAD;
                        end
                    endcase
                end
            end
        endcase
    end

    // Control and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= bfd_pkg::PH_HEAD;
            r_len       <= '0;
            r_fill      <= '0;
            r_xor       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_len       <= n_len;
            r_fill      <= n_fill;
            r_xor       <= n_xor;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pay  <= n_out_pay;
        r_out_idx  <= n_out_idx;
        r_out_len  <= n_out_len;
        r_out_has  <= n_out_has;
        r_out_last <= n_out_last;
    end

    // Payload RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= b;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    // Checks
    a_fill_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == bfd_pkg::PH_DATA) |-> (r_fill < r_len))
        else $error("fill count reached frame length in payload phase");

    a_drain_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == bfd_pkg::PH_READ) |-> (r_k < r_len && r_len <= limit))
        else $error("drain index outside frame");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last && r_out_has) |->
        ({1'b0, r_out_idx} + 1'b1 == r_out_len))
        else $error("last result index does not match frame length");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_has) |-> (r_out_len == '0 && r_out_last))
        else $error("empty-frame result malformed");

    a_drain_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_phase == bfd_pkg::PH_TAIL && b == r_tail_byte && r_len != '0)
        |=> (r_phase == bfd_pkg::PH_READ && r_k == '0))
        else $error("good tail did not start payload drain");

endmodule

`default_nettype wire
